/* rtl/gncg_pkg.sv */
package gncg_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;

    localparam int LOC_W    = 24;
    localparam int TLOC_W   = LOC_W + 1;   // doubled location
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int PITCH_W  = 16;
    localparam int CENTRE_W = 25;          // (2*idx+1)*pitch
    localparam int DIFF_W   = 27;
    localparam int ABS_W    = 26;
    localparam int SQ_W     = 2 * ABS_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int OUT_D_W  = 54;
    localparam int LIN_W    = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH   = 2'd2;

    localparam logic [CNT_W-1:0]   RST_COLUMNS = 9'd16;
    localparam logic [CNT_W-1:0]   RST_ROWS    = 9'd16;
    localparam logic [PITCH_W-1:0] RST_PITCH   = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_X,
        ST_WAIT_X,
        ST_INIT_Y,
        ST_WAIT_Y,
        ST_CAND,
        ST_WAIT_C,
        ST_FINISH
    } t_state;

    // neighbour test order
    typedef enum logic [1:0] {
        DIR_UP,
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT
    } t_dir;

    typedef struct packed {
        logic [CNT_W-1:0]   columns;   // effective, 1..MAX_COLUMNS
        logic [CNT_W-1:0]   rows;      // effective, 1..MAX_ROWS
        logic [PITCH_W-1:0] pitch;
    } t_grid_cfg;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
                                                     input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] res;
        if (n == '0) begin
            res = CNT_W'(1);
        end else if (n > maxv) begin
            res = maxv;
        end else begin
            res = n;
        end
        return res;
    endfunction

endpackage

/* rtl/gncg_cfg_regs.sv */
module gncg_cfg_regs
    import gncg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_grid_cfg             o_cfg
);

    logic [CNT_W-1:0]   r_columns;
    logic [CNT_W-1:0]   r_rows;
    logic [PITCH_W-1:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= RST_COLUMNS;
            r_rows    <= RST_ROWS;
            r_pitch   <= RST_PITCH;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_COLUMNS: r_columns <= i_wr_data[CNT_W-1:0];
                CFG_ROWS:    r_rows    <= i_wr_data[CNT_W-1:0];
                CFG_PITCH:   r_pitch   <= i_wr_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.columns = clamp_count(r_columns, CNT_W'(MAX_COLUMNS));
        o_cfg.rows    = clamp_count(r_rows, CNT_W'(MAX_ROWS));
        o_cfg.pitch   = r_pitch;
    end

endmodule

/* rtl/gncg_axis_unit.sv */
module gncg_axis_unit
    import gncg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TLOC_W-1:0]  i_twice_loc,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic [PITCH_W-1:0] i_pitch,
    output logic               o_done,
    output logic [SQ_W-1:0]    o_sq
);

    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic [CENTRE_W-1:0] r_centre;
    logic [TLOC_W-1:0]   r_loc;
    logic [ABS_W-1:0]    r_abs;
    logic [SQ_W-1:0]     r_sq;

    logic [CENTRE_W-1:0] w_centre;
    logic [DIFF_W-1:0]   w_diff;
    logic [DIFF_W-1:0]   w_mag;

    // doubled centre of the cell: (2*idx+1)*pitch
    assign w_centre = {{(CENTRE_W-IDX_W-1){1'b0}}, i_idx, 1'b1}
                    * {{(CENTRE_W-PITCH_W){1'b0}}, i_pitch};

    assign w_diff = {{(DIFF_W-TLOC_W){r_loc[TLOC_W-1]}}, r_loc}
                  - {{(DIFF_W-CENTRE_W){1'b0}}, r_centre};
    assign w_mag  = w_diff[DIFF_W-1] ? (~w_diff + DIFF_W'(1)) : w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_centre <= w_centre;
        r_loc    <= i_twice_loc;
        r_abs    <= w_mag[ABS_W-1:0];
        r_sq     <= {{ABS_W{1'b0}}, r_abs} * {{ABS_W{1'b0}}, r_abs};
    end

    assign o_done = r_v3;
    assign o_sq   = r_sq;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 3))
        else $error("axis result without a matching start");

endmodule

/* rtl/grid_nearest_cell_greedy_walk.sv */
// walk: each neighbour test is one pass through the shared axis square unit
//   (3-stage pipeline), and neighbours off the grid are skipped without a pass; a walk
//   makes T <= 4*(M+1) neighbour tests, where M <= columns+rows-2 is its number of moves
// throughput: one item at a time; next input taken the cycle after the result
//   is registered, the output register holds a result until it is taken
// reset: synchronous active low, registers return to 16 columns, 16 rows, pitch 1.0
module grid_nearest_cell_greedy_walk
    import gncg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [LOC_W-1:0]      i_loc_x,
    input  logic [LOC_W-1:0]      i_loc_y,
    input  logic [IDX_W-1:0]      i_start_column,
    input  logic [IDX_W-1:0]      i_start_row,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [IDX_W-1:0]      o_nearest_column,
    output logic [IDX_W-1:0]      o_nearest_row,
    output logic [LIN_W-1:0]      o_nearest_index,
    output logic [OUT_D_W-1:0]    o_squared_distance,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_grid_cfg w_cfg;

    t_state r_state;
    t_state n_state;
    t_dir   r_dir;

    logic [TLOC_W-1:0] r_tx;
    logic [TLOC_W-1:0] r_ty;
    logic [IDX_W-1:0]  r_col;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_cand_idx;
    logic [SQ_W-1:0]   r_sx;
    logic [SQ_W-1:0]   r_sy;
    logic [DIST_W-1:0] r_dist;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_res_col;
    logic [IDX_W-1:0]    r_res_row;
    logic [LIN_W-1:0]    r_res_index;
    logic [OUT_D_W-1:0]  r_res_dist;

    logic              w_axis_start;
    logic [TLOC_W-1:0] w_axis_loc;
    logic [IDX_W-1:0]  w_axis_idx;
    logic              w_axis_done;
    logic [SQ_W-1:0]   w_axis_sq;

    logic              w_cand_ok;
    logic              w_vert;
    logic [DIST_W-1:0] w_new_dist;
    logic              w_take;
    logic              w_accept;
    logic              w_out_free;
    logic [IDX_W-1:0]  w_start_col;
    logic [IDX_W-1:0]  w_start_row;
    logic [CNT_W+IDX_W-1:0] w_lin;

    gncg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    gncg_axis_unit u_axis (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_axis_start),
        .i_twice_loc (w_axis_loc),
        .i_idx       (w_axis_idx),
        .i_pitch     (w_cfg.pitch),
        .o_done      (w_axis_done),
        .o_sq        (w_axis_sq)
    );

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;

    // start cell clamped to the grid
    assign w_start_col = ({1'b0, i_start_column} >= w_cfg.columns) ?
                         IDX_W'(w_cfg.columns - CNT_W'(1)) : i_start_column;
    assign w_start_row = ({1'b0, i_start_row} >= w_cfg.rows) ?
                         IDX_W'(w_cfg.rows - CNT_W'(1)) : i_start_row;

    always_comb begin
        case (r_dir)
            DIR_UP:    w_cand_ok = (r_row != '0);
            DIR_RIGHT: w_cand_ok = (({1'b0, r_col} + CNT_W'(1)) < w_cfg.columns);
            DIR_DOWN:  w_cand_ok = (({1'b0, r_row} + CNT_W'(1)) < w_cfg.rows);
            DIR_LEFT:  w_cand_ok = (r_col != '0);
            default:   w_cand_ok = 1'b0;
        endcase
    end

    assign w_vert     = (r_dir == DIR_UP) || (r_dir == DIR_DOWN);
    assign w_new_dist = w_vert ? ({1'b0, r_sx} + {1'b0, w_axis_sq})
                               : ({1'b0, r_sy} + {1'b0, w_axis_sq});
    assign w_take     = (w_new_dist < r_dist);

    assign w_lin = {{CNT_W{1'b0}}, r_row} * {{IDX_W{1'b0}}, w_cfg.columns}
                 + {{CNT_W{1'b0}}, r_col};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_INIT_X;
            ST_INIT_X: n_state = ST_WAIT_X;
            ST_WAIT_X: if (w_axis_done) n_state = ST_INIT_Y;
            ST_INIT_Y: n_state = ST_WAIT_Y;
            ST_WAIT_Y: if (w_axis_done) n_state = ST_CAND;
            ST_CAND: begin
                if (w_cand_ok) begin
                    n_state = ST_WAIT_C;
                end else if (r_dir == DIR_LEFT) begin
                    n_state = ST_FINISH;
                end
            end
            ST_WAIT_C: begin
                if (w_axis_done) begin
                    if (!w_take && (r_dir == DIR_LEFT)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_CAND;
                    end
                end
            end
            ST_FINISH: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // shared unit issue
    always_comb begin
        w_axis_start = 1'b0;
        w_axis_loc   = r_tx;
        w_axis_idx   = r_col;
        case (r_state)
            ST_INIT_X: begin
                w_axis_start = 1'b1;
            end
            ST_INIT_Y: begin
                w_axis_start = 1'b1;
                w_axis_loc   = r_ty;
                w_axis_idx   = r_row;
            end
            ST_CAND: begin
                w_axis_start = w_cand_ok;
                case (r_dir)
                    DIR_UP: begin
                        w_axis_loc = r_ty;
                        w_axis_idx = r_row - IDX_W'(1);
                    end
                    DIR_RIGHT: w_axis_idx = r_col + IDX_W'(1);
                    DIR_DOWN: begin
                        w_axis_loc = r_ty;
                        w_axis_idx = r_row + IDX_W'(1);
                    end
                    DIR_LEFT:  w_axis_idx = r_col - IDX_W'(1);
                    default:   w_axis_idx = r_col;
                endcase
            end
            default: w_axis_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_tx  <= {i_loc_x, 1'b0};
                    r_ty  <= {i_loc_y, 1'b0};
                    r_col <= w_start_col;
                    r_row <= w_start_row;
                end
            end
            ST_WAIT_X: begin
                if (w_axis_done) r_sx <= w_axis_sq;
            end
            ST_WAIT_Y: begin
                if (w_axis_done) begin
                    r_sy   <= w_axis_sq;
                    r_dist <= {1'b0, r_sx} + {1'b0, w_axis_sq};
                    r_dir  <= DIR_UP;
                end
            end
            ST_CAND: begin
                r_cand_idx <= w_axis_idx;
                if (!w_cand_ok && (r_dir != DIR_LEFT)) begin
                    r_dir <= t_dir'(r_dir + 2'd1);
                end
            end
            ST_WAIT_C: begin
                if (w_axis_done) begin
                    if (w_take) begin
                        r_dist <= w_new_dist;
                        r_dir  <= DIR_UP;
                        if (w_vert) begin
                            r_row <= r_cand_idx;
                            r_sy  <= w_axis_sq;
                        end else begin
                            r_col <= r_cand_idx;
                            r_sx  <= w_axis_sq;
                        end
                    end else if (r_dir != DIR_LEFT) begin
                        r_dir <= t_dir'(r_dir + 2'd1);
                    end
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    r_res_col   <= r_col;
                    r_res_row   <= r_row;
                    r_res_index <= w_lin[LIN_W-1:0];
                    r_res_dist  <= {{(OUT_D_W-DIST_W){1'b0}}, r_dist};
                end
            end
            default: ;
        endcase
    end

    assign o_valid            = r_out_valid;
    assign o_nearest_column   = r_res_col;
    assign o_nearest_row      = r_res_row;
    assign o_nearest_index    = r_res_index;
    assign o_squared_distance = r_res_dist;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_axis_done |-> (r_state == ST_WAIT_X || r_state == ST_WAIT_Y ||
                         r_state == ST_WAIT_C))
        else $error("axis result arrived outside a wait state");

    a_move_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT_C && w_axis_done && w_take) |=> (r_dist < $past(r_dist)))
        else $error("walk moved without reducing the distance");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FINISH))
        else $error("result registered outside the finish state");

endmodule

/* verif/grid_nearest_cell_greedy_walk_check.sv */
module grid_nearest_cell_greedy_walk_check
    import gncg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic [LOC_W-1:0]      i_loc_x,
    input  logic [LOC_W-1:0]      i_loc_y,
    input  logic [IDX_W-1:0]      i_start_column,
    input  logic [IDX_W-1:0]      i_start_row,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  logic [IDX_W-1:0]      o_nearest_column,
    input  logic [IDX_W-1:0]      o_nearest_row,
    input  logic [LIN_W-1:0]      o_nearest_index,
    input  logic [OUT_D_W-1:0]    o_squared_distance,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]   column;
        logic [IDX_W-1:0]   row;
        logic [LIN_W-1:0]   index;
        logic [OUT_D_W-1:0] sq_dist;
    } t_cell_result;

    logic [CNT_W-1:0]   reg_columns;
    logic [CNT_W-1:0]   reg_rows;
    logic [PITCH_W-1:0] reg_pitch;

    t_cell_result expected_cells[$];

    // register value as the walk sees it: zero means one, large values saturate
    function automatic int unsigned usable_count(input logic [CNT_W-1:0] n,
                                                 input int unsigned limit);
        if (n == '0) begin
            return 1;
        end
        if (n > limit) begin
            return limit;
        end
        return 32'(n);
    endfunction

    // doubled coordinates keep the half-cell offset exact
    function automatic longint unsigned axis_err_sq(input longint twice_loc,
                                                    input int unsigned idx,
                                                    input longint pitch);
        longint diff;
        diff = twice_loc - longint'(2 * idx + 1) * pitch;
        if (diff < 0) begin
            diff = -diff;
        end
        return diff * diff;
    endfunction

    function automatic longint unsigned centre_dist_sq(input longint tx, input longint ty,
                                                       input int unsigned c,
                                                       input int unsigned r,
                                                       input longint pitch);
        return axis_err_sq(tx, c, pitch) + axis_err_sq(ty, r, pitch);
    endfunction

    function automatic t_cell_result walk_to_nearest(input logic [LOC_W-1:0] lx,
                                                     input logic [LOC_W-1:0] ly,
                                                     input logic [IDX_W-1:0] sc,
                                                     input logic [IDX_W-1:0] sr);
        int unsigned     cols;
        int unsigned     rows;
        int unsigned     c;
        int unsigned     r;
        longint          tx;
        longint          ty;
        longint          p;
        longint unsigned d;
        bit              moved;
        t_cell_result    res;
        cols = usable_count(reg_columns, MAX_COLUMNS);
        rows = usable_count(reg_rows, MAX_ROWS);
        p = longint'(reg_pitch);
        tx = 2 * longint'($signed(lx));
        ty = 2 * longint'($signed(ly));
        c = (32'(sc) >= cols) ? cols - 1 : 32'(sc);
        r = (32'(sr) >= rows) ? rows - 1 : 32'(sr);
        d = centre_dist_sq(tx, ty, c, r, p);
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            // first strictly closer neighbour wins: up, right, down, left
            if (r > 0 && centre_dist_sq(tx, ty, c, r - 1, p) < d) begin
                r = r - 1;
                moved = 1'b1;
            end else if (c + 1 < cols && centre_dist_sq(tx, ty, c + 1, r, p) < d) begin
                c = c + 1;
                moved = 1'b1;
            end else if (r + 1 < rows && centre_dist_sq(tx, ty, c, r + 1, p) < d) begin
                r = r + 1;
                moved = 1'b1;
            end else if (c > 0 && centre_dist_sq(tx, ty, c - 1, r, p) < d) begin
                c = c - 1;
                moved = 1'b1;
            end
            if (moved) begin
                d = centre_dist_sq(tx, ty, c, r, p);
            end
        end
        res.column  = IDX_W'(c);
        res.row     = IDX_W'(r);
        res.index   = LIN_W'(r * cols + c);
        res.sq_dist = OUT_D_W'(d);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result got;
        t_cell_result want;
        if (!i_rst_n) begin
            reg_columns = RST_COLUMNS;
            reg_rows    = RST_ROWS;
            reg_pitch   = RST_PITCH;
            expected_cells.delete();
            outstanding = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLUMNS: reg_columns = i_cfg_data[CNT_W-1:0];
                    CFG_ROWS:    reg_rows    = i_cfg_data[CNT_W-1:0];
                    CFG_PITCH:   reg_pitch   = i_cfg_data[PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                expected_cells.push_back(walk_to_nearest(i_loc_x, i_loc_y,
                                                         i_start_column, i_start_row));
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                got = '{o_nearest_column, o_nearest_row, o_nearest_index,
                        o_squared_distance};
                if (expected_cells.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("[%0t] result with nothing pending: col %0d row %0d",
                                 $realtime, got.column, got.row);
                    end
                    mismatches++;
                end else begin
                    want = expected_cells.pop_front();
                    if (got.column !== want.column || got.row !== want.row ||
                        got.index !== want.index || got.sq_dist !== want.sq_dist) begin
                        if (mismatches < 10) begin
                            $display("[%0t] wrong result (expected / actual):", $realtime);
                            $display("  column %0d / %0d  row %0d / %0d  index %0d / %0d",
                                     want.column, got.column, want.row, got.row,
                                     want.index, got.index);
                            $display("  squared distance %0d / %0d", want.sq_dist,
                                     got.sq_dist);
                        end
                        mismatches++;
                    end
                end
            end
            outstanding = expected_cells.size();
        end
    end

endmodule

/* verif/grid_nearest_cell_greedy_walk_test.sv */
module grid_nearest_cell_greedy_walk_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gncg_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [LOC_W-1:0]      i_loc_x = '0;
    logic [LOC_W-1:0]      i_loc_y = '0;
    logic [IDX_W-1:0]      i_start_column = '0;
    logic [IDX_W-1:0]      i_start_row = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b1;
    logic [IDX_W-1:0]      o_nearest_column;
    logic [IDX_W-1:0]      o_nearest_row;
    logic [LIN_W-1:0]      o_nearest_index;
    logic [OUT_D_W-1:0]    o_squared_distance;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_COLUMNS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatches;
    int outstanding;
    int results_seen;

    int send_idle_pct = 25;
    int recv_idle_pct = 64;
    int hold_left = 0;
    int items_sent = 0;
    int settings_seen = 0;

    grid_nearest_cell_greedy_walk uut (.*);

    grid_nearest_cell_greedy_walk_check chk (.*);

    always #6 i_clk = ~i_clk;

    // result side: long hold-off when requested, random stall otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        #200000000;
        $display("timeout: %0d transactions sent, %0d still pending", items_sent, outstanding);
        $display("grid_nearest_cell_greedy_walk: mismatch");
        $finish;
    end

    function automatic int unsigned usable_cells(input int data, input int unsigned limit);
        int unsigned n;
        n = data & 'h1FF;
        if (n == 0) begin
            return 1;
        end
        return (n > limit) ? limit : n;
    endfunction

    // mostly near the grid, some on centres and boundaries, some anywhere
    function automatic logic [LOC_W-1:0] pick_coord(input int unsigned cnt,
                                                    input int unsigned pitch);
        longint      span;
        longint      v;
        int unsigned sel;
        span = longint'(cnt) * pitch;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            return LOC_W'($urandom());
        end
        if (sel < 30) begin
            v = longint'($urandom_range(0, 2 * cnt)) * pitch / 2;
        end else begin
            v = longint'($urandom_range(0, 32'(span + span / 2))) - span / 4;
        end
        if (v > 8388607) begin
            v = 8388607;
        end
        if (v < -8388608) begin
            v = -8388608;
        end
        return v[LOC_W-1:0];
    endfunction

    task automatic send_item(input logic [LOC_W-1:0] x, input logic [LOC_W-1:0] y,
                             input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_loc_x        <= x;
        i_loc_y        <= y;
        i_start_column <= c;
        i_start_row    <= r;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait until every pending result is back
    task automatic settle();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic run_setting(input int cols_data, input int rows_data,
                               input int pitch, input int n);
        int unsigned cols;
        int unsigned rows;
        logic [IDX_W-1:0] sc;
        logic [IDX_W-1:0] sr;
        settle();
        write_reg(CFG_COLUMNS, CFG_DATA_W'(cols_data));
        write_reg(CFG_ROWS, CFG_DATA_W'(rows_data));
        write_reg(CFG_PITCH, CFG_DATA_W'(pitch));
        settings_seen++;
        cols = usable_cells(cols_data, MAX_COLUMNS);
        rows = usable_cells(rows_data, MAX_ROWS);
        for (int k = 0; k < n; k++) begin
            sc = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 255))
                                             : IDX_W'($urandom_range(0, cols - 1));
            sr = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 255))
                                             : IDX_W'($urandom_range(0, rows - 1));
            send_item(pick_coord(cols, pitch), pick_coord(rows, pitch), sc, sr);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid: 16 x 16 cells, pitch 1.0
        send_item(24'h800000, 24'h800000, 8'd0, 8'd0);
        send_item(24'h7FFFFF, 24'h7FFFFF, 8'd255, 8'd255);
        send_item(24'h7FFFFF, 24'h800000, 8'd0, 8'd255);
        send_item(24'h800000, 24'h7FFFFF, 8'd255, 8'd0);
        send_item(24'd0, 24'd0, 8'd15, 8'd15);
        send_item(24'd1408, 24'd2432, 8'd5, 8'd9);      // exactly on a centre
        send_item(24'd512, 24'd896, 8'd1, 8'd3);        // tie with right neighbour
        send_item(24'd512, 24'd896, 8'd2, 8'd3);        // tie with left neighbour
        send_item(24'd896, 24'd512, 8'd3, 8'd1);        // tie with lower neighbour
        send_item(24'd896, 24'd512, 8'd3, 8'd2);        // tie with upper neighbour
        send_item(24'd2700, 24'd600, 8'd3, 8'd8);       // up first, then right
        send_item(24'd1000, 24'd1000, 8'd200, 8'd100);  // start off the grid
        send_item(24'h0000AA, 24'h000155, 8'hAA, 8'h55);

        run_setting(16, 16, 256, 60);
        run_setting(1, 1, 65535, 10);
        run_setting(0, 5, 1, 15);
        run_setting(511, 300, 1, 6);
        run_setting(256, 256, 65535, 8);

        send_idle_pct = 64;
        recv_idle_pct = 25;
        run_setting('hFE07, 13, 1000, 60);
        run_setting(10, 0, 0, 12);
        run_setting(40, 25, 3, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        hold_left <= 3000;
        run_setting(32, 3, 37, 60);
        run_setting(20, 1, 512, 25);

        settle();
        $display("ran %0d transactions over %0d grid settings, %0d results checked",
                 items_sent, settings_seen + 1, results_seen);
        $display("grids from 1x1 to 256x256, zero and full-scale pitch, clamped starts");
        if (mismatches == 0) begin
            $display("grid_nearest_cell_greedy_walk: match");
        end else begin
            $display("grid_nearest_cell_greedy_walk: mismatch");
        end
        $finish;
    end

endmodule
